@@ rtl/core/battery_level_monitor_assert.svh @@
// Assertion macros for the battery level monitor.
// Used by battery_level_monitor.sv; no other dependencies.
`ifndef BATTERY_LEVEL_MONITOR_ASSERT_SVH
`define BATTERY_LEVEL_MONITOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BLM_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/blm_pkg.sv @@
// Shared types, constants and helper functions of the battery level monitor.
// No dependencies; the modules refer to it by scoped names, the testbench imports it.
`default_nettype none

package blm_pkg;

    localparam int ADC_BITS      = 11;
    localparam int DIVIDER_RATIO = 3;
    localparam int SMOOTH_WEIGHT = 3;
    localparam int CNT_W         = 8;
    localparam int SUM_W         = ADC_BITS + CNT_W;
    localparam int MV_W          = 13;
    localparam int PCT_W         = 7;
    localparam int SCALE_W       = ADC_BITS + 3;     // ratio up to 7
    localparam int SMOOTH_W      = MV_W + 3;
    localparam int DIV_CNT_W     = $clog2(SUM_W + 1);
    localparam int SPAN_W        = 8;                // widest curve segment fits here

    localparam int IN_TDATA_W    = 16;
    localparam int OUT_FIELDS_W  = 4 * MV_W + PCT_W + 1 + 2;
    localparam int OUT_TDATA_W   = 64;
    localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 13;

    // Measurement queue; depth must be a power of two.
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

    localparam logic [MV_W-1:0] MV_LIMIT = '1;
    localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

    localparam int CURVE_POINTS = 8;
    localparam int SEG_W        = $clog2(CURVE_POINTS);
    localparam logic [MV_W-1:0] CURVE_MV [CURVE_POINTS] = '{
        13'd3400, 13'd3550, 13'd3650, 13'd3750, 13'd3850, 13'd3950, 13'd4100, 13'd4200
    };
    localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_POINTS] = '{
        7'd0, 7'd15, 7'd30, 7'd50, 7'd65, 7'd80, 7'd90, 7'd100
    };

    localparam logic [MV_W-1:0] CFG_SAMPLE_COUNT_RST = 13'd16;
    localparam logic [MV_W-1:0] CFG_PRESENT_MIN_RST  = 13'd2500;
    localparam logic [MV_W-1:0] CFG_PRESENT_MAX_RST  = 13'd4350;
    localparam logic [PCT_W-1:0] CFG_LOW_ENTER_RST   = 7'd15;
    localparam logic [PCT_W-1:0] CFG_LOW_EXIT_RST    = 7'd25;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SAMPLE_COUNT = 3'd0,
        CFG_PRESENT_MIN  = 3'd1,
        CFG_PRESENT_MAX  = 3'd2,
        CFG_LOW_ENTER    = 3'd3,
        CFG_LOW_EXIT     = 3'd4
    } cfg_index_t;

    typedef enum logic [1:0] {
        LEVEL_UNKNOWN = 2'd0,
        LEVEL_NORMAL  = 2'd1,
        LEVEL_LOW     = 2'd2
    } level_state_t;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_DIV_AVG = 6'b000010,
        ST_EVAL    = 6'b000100,
        ST_SEG     = 6'b001000,
        ST_DIV_PCT = 6'b010000,
        ST_EMIT    = 6'b100000
    } back_state_t;

    // One finished measurement, handed from the front to the back.
    typedef struct packed {
        logic [SUM_W-1:0]    sum;
        logic [CNT_W-1:0]    count;
        logic [ADC_BITS-1:0] sample_lo;
        logic [ADC_BITS-1:0] sample_hi;
    } meas_job_t;

    typedef struct packed {
        logic [MV_W-1:0]  present_min;
        logic [MV_W-1:0]  present_max;
        logic [PCT_W-1:0] low_enter;
        logic [PCT_W-1:0] low_exit;
    } back_cfg_t;

    typedef struct packed {
        logic             start;
        logic [SUM_W-1:0] dividend;
        logic [CNT_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [SUM_W-1:0] quotient;
    } div_rsp_t;

    // Multiply by the divider ratio and clamp to the millivolt range.
    function automatic logic [MV_W-1:0] scale_sat(input logic [ADC_BITS-1:0] v);
        logic [SCALE_W-1:0] s;
        s = SCALE_W'(v) * SCALE_W'(DIVIDER_RATIO);
        return (s > SCALE_W'(MV_LIMIT)) ? MV_LIMIT : s[MV_W-1:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/blm_front.sv @@
// Front end: takes sample transfers, keeps sum, count, min and max, and queues
// one job per measurement with a good sample. Depends on blm_pkg.
`default_nettype none

module blm_front (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [blm_pkg::IN_TDATA_W-1:0]    s_tdata,   // [10:0] adc_mv
    input  wire logic                              s_tuser,   // [0] sample_ok
    input  wire logic [blm_pkg::CNT_W-1:0]         sample_count,
    input  wire logic                              fifo_full,
    output logic                                   push,
    output blm_pkg::meas_job_t                     job
);

    logic [blm_pkg::CNT_W-1:0]    index_reg, ok_count_reg;
    logic [blm_pkg::SUM_W-1:0]    sum_reg;
    logic [blm_pkg::ADC_BITS-1:0] lo_reg, hi_reg;

    logic [blm_pkg::CNT_W-1:0]    ok_count_next;
    logic [blm_pkg::SUM_W-1:0]    sum_next;
    logic [blm_pkg::ADC_BITS-1:0] lo_next, hi_next, mv;
    logic                         ok, accept, last;

    assign s_tready = !fifo_full;
    assign accept   = s_tvalid && s_tready;
    assign mv       = s_tdata[blm_pkg::ADC_BITS-1:0];
    assign ok       = s_tuser;

    always_comb begin
        ok_count_next = ok_count_reg + blm_pkg::CNT_W'(ok);
        sum_next      = ok ? sum_reg + blm_pkg::SUM_W'(mv) : sum_reg;
        lo_next       = (ok && mv < lo_reg) ? mv : lo_reg;
        hi_next       = (ok && mv > hi_reg) ? mv : hi_reg;
        // zero count ends every sample, same as one
        last          = ({1'b0, index_reg} + 1'b1) >= {1'b0, sample_count};
    end

    assign push = accept && last && (ok_count_next != '0);
    assign job  = '{sum: sum_next, count: ok_count_next,
                    sample_lo: lo_next, sample_hi: hi_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_reg    <= '0;
            ok_count_reg <= '0;
            sum_reg      <= '0;
            lo_reg       <= '1;
            hi_reg       <= '0;
        end else if (accept) begin
            if (last) begin
                index_reg    <= '0;
                ok_count_reg <= '0;
                sum_reg      <= '0;
                lo_reg       <= '1;
                hi_reg       <= '0;
            end else begin
                index_reg    <= index_reg + 1'b1;
                ok_count_reg <= ok_count_next;
                sum_reg      <= sum_next;
                lo_reg       <= lo_next;
                hi_reg       <= hi_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/blm_fifo.sv @@
// Short job queue between front and back so either side can stall alone.
// Depends on blm_pkg.
`default_nettype none

module blm_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  blm_pkg::meas_job_t      job_in,
    output logic                    full,
    input  wire logic               pop,
    output blm_pkg::meas_job_t      job_out,
    output logic                    empty
);

    blm_pkg::meas_job_t                 mem_reg [blm_pkg::FIFO_DEPTH];
    logic [blm_pkg::FIFO_PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [blm_pkg::FIFO_CNT_W-1:0]     count_reg;

    assign full    = count_reg == blm_pkg::FIFO_CNT_W'(blm_pkg::FIFO_DEPTH);
    assign empty   = count_reg == '0;
    assign job_out = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            priority if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end else begin
                count_reg <= count_reg;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/blm_div.sv @@
// Restoring serial divider, one quotient bit per cycle, shared by the mean
// and the curve interpolation. Depends on blm_pkg.
`default_nettype none

module blm_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  blm_pkg::div_req_t   req,
    output blm_pkg::div_rsp_t   rsp
);

    logic [blm_pkg::CNT_W-1:0]     rem_reg, divisor_reg;
    logic [blm_pkg::SUM_W-1:0]     quo_reg;
    logic [blm_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          busy_reg, done_reg;

    logic [blm_pkg::CNT_W:0]       trial;
    logic                          fits;

    assign trial = {rem_reg, quo_reg[blm_pkg::SUM_W-1]};
    assign fits  = trial >= {1'b0, divisor_reg};

    assign rsp = '{busy: busy_reg, done: done_reg, quotient: quo_reg};

    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the top bit drops out
            rem_reg <= fits ? blm_pkg::CNT_W'(trial - {1'b0, divisor_reg})
                            : trial[blm_pkg::CNT_W-1:0];
            quo_reg <= {quo_reg[blm_pkg::SUM_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= blm_pkg::DIV_CNT_W'(blm_pkg::SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == blm_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/blm_back.sv @@
// Back end: mean, scaling, presence, smoothing, curve lookup, low latch and
// the output register. Depends on blm_pkg; drives the shared divider.
`default_nettype none

module blm_back (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  blm_pkg::back_cfg_t                     cfg,
    input  wire logic                              fifo_empty,
    input  blm_pkg::meas_job_t                     job,
    output logic                                   pop,
    output blm_pkg::div_req_t                      div_req,
    input  blm_pkg::div_rsp_t                      div_rsp,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [blm_pkg::OUT_TDATA_W-1:0]        m_tdata
);

    blm_pkg::back_state_t state_reg, state_next;

    logic [blm_pkg::MV_W-1:0]  lo_reg, hi_reg, avg_reg, disp_reg, filt_reg;
    logic [blm_pkg::PCT_W-1:0] base_reg, pct_reg;
    logic                      present_reg;
    logic                      status_valid_reg, last_present_reg, low_latched_reg;
    logic                      m_valid_reg;
    logic [blm_pkg::OUT_TDATA_W-1:0] m_data_reg;

    // evaluation
    logic                            present_c, smooth;
    logic [blm_pkg::SMOOTH_W-1:0]    smooth_sum;
    logic [blm_pkg::MV_W-1:0]        disp_c;

    // curve segment
    logic                            below, above, seg_mid;
    logic [blm_pkg::SEG_W-1:0]       seg, seg_lo;
    logic [blm_pkg::SPAN_W-1:0]      off, span;
    logic [blm_pkg::PCT_W-1:0]       dp;
    logic [blm_pkg::SPAN_W+blm_pkg::PCT_W-1:0] prod;

    // emit
    logic                            out_free, latch_next;
    blm_pkg::level_state_t           level;

    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        present_c  = (avg_reg >= cfg.present_min) && (avg_reg <= cfg.present_max);
        smooth     = present_c && status_valid_reg && last_present_reg;
        smooth_sum = blm_pkg::SMOOTH_W'(filt_reg) * blm_pkg::SMOOTH_W'(blm_pkg::SMOOTH_WEIGHT)
                   + blm_pkg::SMOOTH_W'(avg_reg) + blm_pkg::SMOOTH_W'(2);
        disp_c     = smooth ? smooth_sum[blm_pkg::MV_W+1:2] : avg_reg;
    end

    always_comb begin
        below = disp_reg <= blm_pkg::CURVE_MV[0];
        above = disp_reg > blm_pkg::CURVE_MV[blm_pkg::CURVE_POINTS-1];
        seg   = blm_pkg::SEG_W'(1);
        for (int i = blm_pkg::CURVE_POINTS - 1; i >= 1; i--) begin
            if (disp_reg <= blm_pkg::CURVE_MV[i]) begin
                seg = blm_pkg::SEG_W'(i);
            end
        end
        seg_mid = !below && !above;
        seg_lo  = seg - 1'b1;
        off     = blm_pkg::SPAN_W'(disp_reg - blm_pkg::CURVE_MV[seg_lo]);
        span    = blm_pkg::SPAN_W'(blm_pkg::CURVE_MV[seg] - blm_pkg::CURVE_MV[seg_lo]);
        dp      = blm_pkg::CURVE_PCT[seg] - blm_pkg::CURVE_PCT[seg_lo];
        prod    = (blm_pkg::SPAN_W + blm_pkg::PCT_W)'(off) * (blm_pkg::SPAN_W + blm_pkg::PCT_W)'(dp);
    end

    always_comb begin
        priority if (!present_reg) begin
            latch_next = 1'b0;
        end else if (pct_reg <= cfg.low_enter) begin
            latch_next = 1'b1;
        end else if (pct_reg >= cfg.low_exit) begin
            latch_next = 1'b0;
        end else begin
            latch_next = low_latched_reg;
        end
        level = !present_reg ? blm_pkg::LEVEL_UNKNOWN
              : (latch_next ? blm_pkg::LEVEL_LOW : blm_pkg::LEVEL_NORMAL);
    end

    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        div_req    = '0;
        unique case (state_reg)
            blm_pkg::ST_IDLE: begin
                if (!fifo_empty) begin
                    pop              = 1'b1;
                    div_req.start    = 1'b1;
                    div_req.dividend = job.sum + blm_pkg::SUM_W'(job.count >> 1);
                    div_req.divisor  = job.count;
                    state_next       = blm_pkg::ST_DIV_AVG;
                end
            end
            blm_pkg::ST_DIV_AVG: begin
                if (div_rsp.done) begin
                    state_next = blm_pkg::ST_EVAL;
                end
            end
            blm_pkg::ST_EVAL: begin
                state_next = blm_pkg::ST_SEG;
            end
            blm_pkg::ST_SEG: begin
                if (present_reg && seg_mid) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = blm_pkg::SUM_W'(prod) + blm_pkg::SUM_W'(span >> 1);
                    div_req.divisor  = blm_pkg::CNT_W'(span);
                    state_next       = blm_pkg::ST_DIV_PCT;
                end else begin
                    state_next = blm_pkg::ST_EMIT;
                end
            end
            blm_pkg::ST_DIV_PCT: begin
                if (div_rsp.done) begin
                    state_next = blm_pkg::ST_EMIT;
                end
            end
            blm_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = blm_pkg::ST_IDLE;
                end
            end
            default: state_next = blm_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            blm_pkg::ST_IDLE: begin
                lo_reg <= blm_pkg::scale_sat(job.sample_lo);
                hi_reg <= blm_pkg::scale_sat(job.sample_hi);
            end
            blm_pkg::ST_DIV_AVG: begin
                // mean never exceeds the largest sample
                avg_reg <= blm_pkg::scale_sat(div_rsp.quotient[blm_pkg::ADC_BITS-1:0]);
            end
            blm_pkg::ST_EVAL: begin
                present_reg <= present_c;
                disp_reg    <= disp_c;
            end
            blm_pkg::ST_SEG: begin
                base_reg <= blm_pkg::CURVE_PCT[seg_lo];
                pct_reg  <= (!present_reg || below) ? '0 : blm_pkg::PCT_FULL;
            end
            blm_pkg::ST_DIV_PCT: begin
                pct_reg <= base_reg + div_rsp.quotient[blm_pkg::PCT_W-1:0];
            end
            blm_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_data_reg <= {{blm_pkg::OUT_PAD_W{1'b0}}, level, present_reg, pct_reg,
                                   hi_reg, lo_reg, disp_reg, avg_reg};
                end
            end
            default: begin
                avg_reg <= avg_reg;
            end
        endcase
    end

    // control and status registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= blm_pkg::ST_IDLE;
            m_valid_reg      <= 1'b0;
            filt_reg         <= '0;
            status_valid_reg <= 1'b0;
            last_present_reg <= 1'b0;
            low_latched_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == blm_pkg::ST_EMIT && out_free) begin
                m_valid_reg      <= 1'b1;
                filt_reg         <= disp_reg;
                status_valid_reg <= 1'b1;
                last_present_reg <= present_reg;
                low_latched_reg  <= latch_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/battery_level_monitor.sv @@
// Battery level monitor, top level. One sample transfer per cycle while the queue has room.
// Per job the back end divides for the mean, evaluates presence and smoothing, picks
// the curve segment, divides again for the percent (skipped when not present or outside
// the curve's sloped part) and registers the result; output stalls hold it, and it takes
// no new job until then. Reset (aresetn low at a clock edge) restores register defaults,
// clears accumulators, smoothing state and the low latch, and drops queued jobs and results.
`default_nettype none
`include "battery_level_monitor_assert.svh"

module battery_level_monitor (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // sample stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [blm_pkg::IN_TDATA_W-1:0]      s_tdata,  // [10:0] adc_mv, rest zero
    input  wire logic                                s_tuser,  // [0] sample_ok
    // result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [12:0] mean_mv, [25:13] battery_mv, [38:26] min_mv, [51:39] max_mv,
    // [58:52] percent, [59] present, [61:60] level_state, [63:62] zero
    output logic [blm_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // register write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [blm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [blm_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Configuration registers. Writes are always taken; unknown indexes drop.
    logic [blm_pkg::CNT_W-1:0]  sample_count_reg;
    logic [blm_pkg::MV_W-1:0]   present_min_reg, present_max_reg;
    logic [blm_pkg::PCT_W-1:0]  low_enter_reg, low_exit_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_count_reg <= blm_pkg::CNT_W'(blm_pkg::CFG_SAMPLE_COUNT_RST);
            present_min_reg  <= blm_pkg::CFG_PRESENT_MIN_RST;
            present_max_reg  <= blm_pkg::CFG_PRESENT_MAX_RST;
            low_enter_reg    <= blm_pkg::CFG_LOW_ENTER_RST;
            low_exit_reg     <= blm_pkg::CFG_LOW_EXIT_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                blm_pkg::CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data[blm_pkg::CNT_W-1:0];
                blm_pkg::CFG_PRESENT_MIN:  present_min_reg  <= cfg_data[blm_pkg::MV_W-1:0];
                blm_pkg::CFG_PRESENT_MAX:  present_max_reg  <= cfg_data[blm_pkg::MV_W-1:0];
                blm_pkg::CFG_LOW_ENTER:    low_enter_reg    <= cfg_data[blm_pkg::PCT_W-1:0];
                blm_pkg::CFG_LOW_EXIT:     low_exit_reg     <= cfg_data[blm_pkg::PCT_W-1:0];
                default: begin
                    sample_count_reg <= sample_count_reg;
                end
            endcase
        end
    end

    blm_pkg::back_cfg_t back_cfg;
    assign back_cfg = '{present_min: present_min_reg, present_max: present_max_reg,
                        low_enter: low_enter_reg, low_exit: low_exit_reg};

    // Front: accumulate a measurement and hand it off as a job.
    logic               front_push, fifo_full, fifo_empty, fifo_pop;
    blm_pkg::meas_job_t front_job, head_job;

    blm_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .sample_count (sample_count_reg),
        .fifo_full    (fifo_full),
        .push         (front_push),
        .job          (front_job)
    );

    // Two-deep job queue: the front keeps sampling while the back computes.
    blm_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (front_push),
        .job_in  (front_job),
        .full    (fifo_full),
        .pop     (fifo_pop),
        .job_out (head_job),
        .empty   (fifo_empty)
    );

    // Back: sequencer plus the shared divider.
    blm_pkg::div_req_t div_req;
    blm_pkg::div_rsp_t div_rsp;

    blm_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    blm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (back_cfg),
        .fifo_empty (fifo_empty),
        .job        (head_job),
        .pop        (fifo_pop),
        .div_req    (div_req),
        .div_rsp    (div_rsp),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    // Checks
    logic div_start, div_busy, absent_out, absent_clean;

    assign div_start    = div_req.start;
    assign div_busy     = div_rsp.busy;
    // absent battery: level unknown and percent zero
    assign absent_out   = m_tvalid && !m_tdata[59];
    assign absent_clean = (m_tdata[61:60] == blm_pkg::LEVEL_UNKNOWN) && (m_tdata[58:52] == '0);

    `BLM_ASSERT_IMPLY(a_queue_room, aclk, aresetn, front_push, !fifo_full, "queue overflow")
    `BLM_ASSERT_IMPLY(a_div_idle, aclk, aresetn, div_start, !div_busy, "divider busy at start")
    `BLM_ASSERT_NEXT(a_div_runs, aclk, aresetn, div_start, div_busy, "divider did not start")
    `BLM_ASSERT_IMPLY(a_level_absent, aclk, aresetn, absent_out, absent_clean, "absent level")

endmodule

`default_nettype wire

@@ verif/battery_level_monitor_tb.sv @@
// Self-checking testbench for battery_level_monitor: drives ADC sample transfers and
// register writes, predicts each reading or uses a hand-typed one, and compares it
// field by field. Depends on blm_pkg and the battery_level_monitor RTL only.
module battery_level_monitor_tb;
    import blm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 8;
    localparam int SAMPLE_TARGET = 1150;
    localparam int CALM_TAIL     = 150;    // last samples go without any idling
    localparam int BIG_ROOM      = 700;    // a 255-sample set needs this many samples left
    localparam int DRAIN_CYCLES  = 120;    // drain time for two queued measurements
    localparam int HOLD_CYCLES   = 400;    // long output back-pressure stretch
    localparam int QUIET_LIMIT   = 4000;   // cycles without any transfer -> hung
    localparam logic [ADC_BITS-1:0] ADC_MAX = '1;

    // Indexes past the register map; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(CFG_LOW_EXIT) + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

    // Mirrors the m_tdata layout, lowest field last.
    typedef struct packed {
        logic [1:0]       pad;
        level_state_t     level;
        logic             present;
        logic [PCT_W-1:0] pct;
        logic [MV_W-1:0]  max_mv;
        logic [MV_W-1:0]  min_mv;
        logic [MV_W-1:0]  battery_mv;
        logic [MV_W-1:0]  mean_mv;
    } reading_t;

    // One row of the directed table: a register write or one sample transfer.
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_IDX_W-1:0]  reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        logic [ADC_BITS-1:0]   mv;
        logic                  ok;
        logic                  typed;   // want holds a hand-computed reading
        reading_t              want;
    } plan_row_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    battery_level_monitor DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #HALF_PERIOD aclk = 1'b1;
        #HALF_PERIOD aclk = 1'b0;
    end

    // Predictor copy of the configuration registers.
    int unsigned meas_count, bound_lo, bound_hi, enter_pct, exit_pct;
    // Predictor copy of the accumulators and the status state.
    int unsigned acc_taken, acc_ok, acc_sum, acc_lo, acc_hi;
    int unsigned shown_mv;
    bit          have_reading, was_present, low_flag;

    reading_t readings_due [$];     // predicted readings, oldest first

    int unsigned items_sent, readings_seen, reg_writes, setups, big_sets, faults;
    int unsigned quiet_cycles;
    bit          gaps_on  = 1'b1;   // random idling on both sides
    bit          hold_req = 1'b0;   // ask the receiver for one long stall
    plan_row_t   plan [$];

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void clear_acc();
        acc_taken = 0;
        acc_ok    = 0;
        acc_sum   = 0;
        acc_lo    = ADC_MAX;
        acc_hi    = 0;
    endfunction

    function automatic int unsigned scaled_mv(input int unsigned v);
        return (v * DIVIDER_RATIO > MV_LIMIT) ? MV_LIMIT : v * DIVIDER_RATIO;
    endfunction

    // Piecewise-linear discharge curve, rounded to the nearest percent.
    function automatic int unsigned curve_lookup(input int unsigned mv);
        int unsigned span, off, rise;
        if (mv <= CURVE_MV[0]) return CURVE_PCT[0];
        for (int i = 1; i < CURVE_POINTS; i++) begin
            if (mv <= CURVE_MV[i]) begin
                span = CURVE_MV[i] - CURVE_MV[i-1];
                off  = mv - CURVE_MV[i-1];
                rise = CURVE_PCT[i] - CURVE_PCT[i-1];
                return CURVE_PCT[i-1] + (off * rise + span / 2) / span;
            end
        end
        return PCT_FULL;
    endfunction

    // Accounts one accepted sample; returns 1 when it closes a measurement
    // that yields a reading.
    function automatic bit take_sample(input logic [ADC_BITS-1:0] mv, input bit ok,
                                       output reading_t r);
        int unsigned n, mean, avg, shown, pct, lo, hi;
        bit          in_range;
        r = '0;
        if (ok) begin
            if (mv < acc_lo) acc_lo = mv;
            if (mv > acc_hi) acc_hi = mv;
            acc_sum += mv;
            acc_ok++;
        end
        acc_taken++;
        // a count of zero closes after every sample, same as one
        if (acc_taken < meas_count) return 1'b0;
        n  = acc_ok;
        lo = acc_lo;
        hi = acc_hi;
        mean = (n != 0) ? (acc_sum + n / 2) / n : 0;
        clear_acc();
        // no good sample: no reading, status state untouched
        if (n == 0) return 1'b0;

        avg      = scaled_mv(mean);
        in_range = (avg >= bound_lo) && (avg <= bound_hi);
        shown    = avg;
        if (in_range && have_reading && was_present)
            shown = (shown_mv * SMOOTH_WEIGHT + avg + 2) / 4;
        have_reading = 1'b1;
        was_present  = in_range;
        shown_mv     = shown & MV_LIMIT;
        pct          = in_range ? curve_lookup(shown) : 0;

        if (!in_range)              low_flag = 1'b0;
        else if (pct <= enter_pct)  low_flag = 1'b1;
        else if (pct >= exit_pct)   low_flag = 1'b0;

        r.mean_mv    = MV_W'(avg);
        r.battery_mv = MV_W'(shown);
        r.min_mv     = MV_W'(scaled_mv(lo));
        r.max_mv     = MV_W'(scaled_mv(hi));
        r.pct        = PCT_W'(pct);
        r.present    = in_range;
        r.level      = !in_range ? LEVEL_UNKNOWN : (low_flag ? LEVEL_LOW : LEVEL_NORMAL);
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Directed table helpers
    // ------------------------------------------------------------------
    function automatic plan_row_t row_reg(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.reg_val = val;
        return row;
    endfunction

    function automatic plan_row_t row_smp(input logic [ADC_BITS-1:0] mv, input bit ok);
        plan_row_t row;
        row = '0;
        row.mv = mv;
        row.ok = ok;
        return row;
    endfunction

    function automatic plan_row_t row_chk(input logic [ADC_BITS-1:0] mv, input reading_t want);
        plan_row_t row;
        row = row_smp(mv, 1'b1);
        row.typed = 1'b1;
        row.want  = want;
        return row;
    endfunction

    function automatic reading_t reading(input int unsigned avg, input int unsigned bat,
                                         input int unsigned lo, input int unsigned hi,
                                         input int unsigned pct, input bit present,
                                         input level_state_t level);
        reading_t r;
        r = '0;
        r.mean_mv    = MV_W'(avg);
        r.battery_mv = MV_W'(bat);
        r.min_mv     = MV_W'(lo);
        r.max_mv     = MV_W'(hi);
        r.pct        = PCT_W'(pct);
        r.present    = present;
        r.level      = level;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // Let everything in flight come out, including measurements with no reading.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write of a batch.
    task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        reg_writes++;
        case (idx)
            CFG_SAMPLE_COUNT: meas_count = val[CNT_W-1:0];
            CFG_PRESENT_MIN:  bound_lo   = val;
            CFG_PRESENT_MAX:  bound_hi   = val;
            CFG_LOW_ENTER:    enter_pct  = val[PCT_W-1:0];
            CFG_LOW_EXIT:     exit_pct   = val[PCT_W-1:0];
            default: ;        // unmapped index, dropped
        endcase
    endtask

    // One sample transfer, with a random idle gap first when gaps are on; s_tvalid stays
    // high after it, so back-to-back transfers need no idle in between.
    task automatic send_sample(input logic [ADC_BITS-1:0] mv, input bit ok,
                               input bit typed, input reading_t want);
        reading_t predicted;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TDATA_W'(mv);
        s_tuser  <= ok;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (take_sample(mv, ok, predicted))
            readings_due.push_back(typed ? want : predicted);
    endtask

    // Fresh random register set, written while the block is idle.
    task automatic random_setup();
        logic [CFG_DATA_W-1:0] v_count, v_lo, v_hi, v_enter, v_exit;
        case ($urandom_range(0, 15))
            0:       v_count = '0;
            1:       v_count = (big_sets < 2 && items_sent + BIG_ROOM < SAMPLE_TARGET)
                               ? CFG_DATA_W'(255) : CFG_DATA_W'(3);
            2:       v_count = CFG_DATA_W'($urandom_range(7, 32));
            default: v_count = CFG_DATA_W'($urandom_range(1, 6));
        endcase
        if (v_count == 255) big_sets++;
        case ($urandom_range(0, 7))
            0: begin v_lo = '0; v_hi = '1; end
            1: begin v_lo = '1; v_hi = '0; end               // crossed bounds
            2: begin v_lo = CFG_DATA_W'($urandom); v_hi = CFG_DATA_W'($urandom); end
            default: begin
                v_lo = CFG_DATA_W'($urandom_range(2300, 3600));
                v_hi = CFG_DATA_W'($urandom_range(3800, 4500));
            end
        endcase
        case ($urandom_range(0, 7))
            // upper bits masked off
            0: begin v_enter = CFG_DATA_W'($urandom); v_exit = CFG_DATA_W'($urandom); end
            1: begin v_enter = '0; v_exit = '0; end
            2: begin v_enter = 100; v_exit = 100; end
            default: begin
                v_enter = CFG_DATA_W'($urandom_range(0, 50));
                v_exit  = CFG_DATA_W'(v_enter + $urandom_range(0, 40));
            end
        endcase
        settle();
        cfg_put(CFG_SAMPLE_COUNT, v_count);
        cfg_put(CFG_PRESENT_MIN, v_lo);
        cfg_put(CFG_PRESENT_MAX, v_hi);
        cfg_put(CFG_LOW_ENTER, v_enter);
        cfg_put(CFG_LOW_EXIT, v_exit);
        cfg_valid <= 1'b0;
        setups++;
    endtask

    // One whole measurement. Most sit in the Li-ion window (x3 divider) so the
    // smoothing and the curve get exercised; some are wild or all failed.
    task automatic run_measurement();
        int unsigned style, mid_mv, mv, span_n;
        bit          all_bad;
        style   = $urandom_range(0, 11);
        all_bad = ($urandom_range(0, 11) == 0);
        mid_mv  = $urandom_range(1080, 1450);
        span_n  = (meas_count == 0) ? 1 : meas_count;
        for (int k = 0; k < span_n; k++) begin
            case (style)
                8, 9:    mv = $urandom_range(0, ADC_MAX);
                10:      mv = $urandom_range(0, 1) ? ADC_MAX : 0;
                11:      mv = $urandom_range(0, 900);
                default: mv = mid_mv - 20 + $urandom_range(0, 40);
            endcase
            send_sample(ADC_BITS'(mv), !all_bad && ($urandom_range(0, 9) != 0), 1'b0, '0);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, plus one long hold on request
    // ------------------------------------------------------------------
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (gaps_on && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker and activity counter
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    always @(posedge aclk) begin
        reading_t due, seen;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                seen = reading_t'(m_tdata);
                if (readings_due.size() == 0) begin
                    $error("reading transfer with nothing expected: %h", m_tdata);
                    faults++;
                end else begin
                    due = readings_due.pop_front();
                    check_field("mean_mv", due.mean_mv, seen.mean_mv);
                    check_field("battery_mv", due.battery_mv, seen.battery_mv);
                    check_field("min_mv", due.min_mv, seen.min_mv);
                    check_field("max_mv", due.max_mv, seen.max_mv);
                    check_field("percent", due.pct, seen.pct);
                    check_field("present", due.present, seen.present);
                    check_field("level_state", due.level, seen.level);
                    check_field("tdata pad", due.pad, seen.pad);
                    readings_seen++;
                end
            end
        end
    end

    // Watchdog: a hang shows up as a long run of cycles with no transfer at all.
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no transfer for %0d cycles, giving up", QUIET_LIMIT);
        $display("battery_level_monitor verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        bit          cfg_open;
        bit          pressure_done;
        int unsigned n_meas;

        meas_count   = CFG_SAMPLE_COUNT_RST;
        bound_lo     = CFG_PRESENT_MIN_RST;
        bound_hi     = CFG_PRESENT_MAX_RST;
        enter_pct    = CFG_LOW_ENTER_RST;
        exit_pct     = CFG_LOW_EXIT_RST;
        shown_mv     = 0;
        have_reading = 1'b0;
        was_present  = 1'b0;
        low_flag     = 1'b0;
        clear_acc();
        cfg_open      = 1'b0;
        pressure_done = 1'b0;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table. Hand-typed readings only where the numbers are obvious.
        plan.push_back(row_reg(CFG_SAMPLE_COUNT, 1));
        plan.push_back(row_chk(ADC_MAX, reading(6141, 6141, 6141, 6141, 0, 0, LEVEL_UNKNOWN)));
        plan.push_back(row_chk(0, reading(0, 0, 0, 0, 0, 0, LEVEL_UNKNOWN)));
        plan.push_back(row_smp(1777, 1'b0));                 // failed sample only: no reading
        plan.push_back(row_chk(1400, reading(4200, 4200, 4200, 4200, 100, 1, LEVEL_NORMAL)));
        plan.push_back(row_smp(1133, 1'b1));                 // smoothing kicks in
        plan.push_back(row_smp(1134, 1'b1));
        plan.push_back(row_smp(1050, 1'b1));                 // mean below the curve's lowest point
        plan.push_back(row_smp(1200, 1'b1));
        plan.push_back(row_reg(CFG_SAMPLE_COUNT, 0));        // zero count acts as one
        plan.push_back(row_smp(1300, 1'b1));
        plan.push_back(row_smp(1000, 1'b0));
        plan.push_back(row_reg(CFG_PRESENT_MIN, '1));        // crossed bounds
        plan.push_back(row_reg(CFG_PRESENT_MAX, '0));
        plan.push_back(row_chk(1300, reading(3900, 3900, 3900, 3900, 0, 0, LEVEL_UNKNOWN)));
        plan.push_back(row_reg(CFG_PRESENT_MIN, '0));
        plan.push_back(row_reg(CFG_PRESENT_MAX, '1));
        plan.push_back(row_reg(CFG_LOW_ENTER, '1));          // thresholds past 100
        plan.push_back(row_reg(CFG_LOW_EXIT, '1));
        plan.push_back(row_smp(1300, 1'b1));
        plan.push_back(row_smp(ADC_MAX, 1'b1));
        plan.push_back(row_reg(CFG_LOW_ENTER, '0));
        plan.push_back(row_reg(CFG_LOW_EXIT, '0));
        plan.push_back(row_reg(REG_UNMAPPED_LO, '1));        // must be ignored
        plan.push_back(row_reg(REG_UNMAPPED_HI, '1));
        plan.push_back(row_smp(1000, 1'b1));
        plan.push_back(row_reg(CFG_SAMPLE_COUNT, 4));
        plan.push_back(row_smp(ADC_MAX, 1'b1));              // mixed ok / failed
        plan.push_back(row_smp(0, 1'b1));
        plan.push_back(row_smp(999, 1'b0));
        plan.push_back(row_smp(1500, 1'b1));
        // all failed
        for (int k = 0; k < 4; k++) plan.push_back(row_smp(ADC_BITS'($urandom), 1'b0));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                if (!cfg_open) settle();
                cfg_put(plan[i].reg_idx, plan[i].reg_val);
                cfg_open = 1'b1;
            end else begin
                if (cfg_open) cfg_valid <= 1'b0;
                cfg_open = 1'b0;
                send_sample(plan[i].mv, plan[i].ok, plan[i].typed, plan[i].want);
            end
        end

        // Random phases, each a new register set and a handful of measurements.
        while (items_sent < SAMPLE_TARGET) begin
            if (!pressure_done && items_sent > SAMPLE_TARGET / 3) begin
                // one reading per sample while the receiver holds off:
                // the queue fills and s_tready must drop
                settle();
                cfg_put(CFG_SAMPLE_COUNT, 1);
                cfg_valid <= 1'b0;
                gaps_on  = 1'b0;
                hold_req = 1'b1;
                repeat (40) run_measurement();
                gaps_on  = 1'b1;
                pressure_done = 1'b1;
            end
            random_setup();
            gaps_on = (items_sent + CALM_TAIL < SAMPLE_TARGET);
            n_meas  = (meas_count >= 7) ? $urandom_range(1, 2) : $urandom_range(3, 12);
            repeat (n_meas) run_measurement();
        end

        s_tvalid <= 1'b0;
        while (readings_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d sample transfers, %0d readings checked, %0d register writes",
                 items_sent, readings_seen, reg_writes);
        $display("%0d random register setups, one %0d-cycle output hold",
                 setups, HOLD_CYCLES);
        if (readings_due.size() != 0) begin
            $error("%0d readings never arrived", readings_due.size());
            faults++;
        end
        if (faults == 0) begin
            $display("battery_level_monitor verification clean");
        end else begin
            $display("battery_level_monitor verification failed");
        end
        $finish;
    end

endmodule

@@ battery_level_monitor.f @@
+incdir+rtl/core
rtl/core/blm_pkg.sv
rtl/core/blm_front.sv
rtl/core/blm_fifo.sv
rtl/core/blm_div.sv
rtl/core/blm_back.sv
rtl/core/battery_level_monitor.sv
verif/battery_level_monitor_tb.sv
